/* sv/phst_pkg.sv */
`default_nettype none

package phst_pkg;

    localparam int NSTAGES        = 8;
    localparam int REG_BITS_DEF   = 5;
    localparam int COUNT_BITS_DEF = 32;
    localparam int CYCLE_RESET    = NSTAGES - 1;

    localparam logic [2:0] ST_IF1  = 3'd0;
    localparam logic [2:0] ST_ID   = 3'd2;
    localparam logic [2:0] ST_EXE1 = 3'd3;
    localparam logic [2:0] ST_MEM2 = 3'd6;
    localparam logic [2:0] ST_WB   = 3'd7;

    typedef enum logic [1:0] {
        ACT_CLOCK = 2'd0,
        ACT_SRC   = 2'd1,
        ACT_DEST  = 2'd2,
        ACT_FLUSH = 2'd3
    } action_t;

    // per-stage control from the sequencer
    typedef struct packed {
        logic shift;
        logic clear;
        logic load;
        logic inc;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* sv/phst_if.sv */
`default_nettype none

interface phst_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [4:0] reg_num;
    logic [2:0] stage;
    logic [3:0] flush_count;

    modport source (output valid, action, reg_num, stage, flush_count, input ready);
    modport sink (input valid, action, reg_num, stage, flush_count, output ready);
endinterface

interface phst_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  bubbles_inserted;
    logic        hazard_found;
    logic [2:0]  hazard_stage;
    logic [31:0] hazard_count;
    logic [31:0] cycle_total;
    logic [31:0] bubble_total;
    logic [31:0] flush_total;

    modport source (
        output valid, bubbles_inserted, hazard_found, hazard_stage, hazard_count,
               cycle_total, bubble_total, flush_total,
        input  ready
    );
    modport sink (
        input  valid, bubbles_inserted, hazard_found, hazard_stage, hazard_count,
               cycle_total, bubble_total, flush_total,
        output ready
    );
endinterface

`default_nettype wire

/* sv/pipeline_hazard_stall_tracker_top.sv */
`default_nettype none

// Tracks an eight-stage pipeline (IF1..WB) as a chain of stage cells, each holding the
// destination register, valid flag and ready stage of the instruction in that stage plus
// that stage's RAW hazard counter. One command item is taken at a time and gives one
// result item. An accepted item passes an evaluate state, then a run state that moves the
// stage chain one position per bubble a source check inserts (0 to 6) or per flush_count
// step of a flush (0 to 15), then a done state; the run state is skipped when there are
// none, and clock commands move the chain in the evaluate state. The result is loaded
// into an output register in the done state and waits there until taken; the next item may
// be accepted meanwhile, but its result is held back until that register is free.
module pipeline_hazard_stall_tracker_top #(
    parameter int REG_BITS   = phst_pkg::REG_BITS_DEF,
    parameter int COUNT_BITS = phst_pkg::COUNT_BITS_DEF
) (
    input wire           clk,
    input wire           rst_n,
    phst_cmd_if.sink     cmd,
    phst_res_if.source   result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_RUN,
        S_DONE
    } state_t;

    localparam int NS = phst_pkg::NSTAGES;

    state_t                state_reg;
    phst_pkg::action_t     act_reg;
    logic [REG_BITS-1:0]   key_reg;
    logic [2:0]            stage_reg;
    logic [3:0]            remain_reg;
    logic [2:0]            at_reg;
    logic                  found_reg;
    logic [2:0]            hstage_reg;
    logic [2:0]            bub_reg;
    logic [COUNT_BITS-1:0] cycle_reg;
    logic [COUNT_BITS-1:0] bubble_reg;
    logic [COUNT_BITS-1:0] flush_reg;

    logic                  out_valid_reg;
    logic [2:0]            out_bub_reg;
    logic                  out_found_reg;
    logic [2:0]            out_hstage_reg;
    logic [31:0]           out_hcount_reg;
    logic [31:0]           out_cycle_reg;
    logic [31:0]           out_bubble_reg;
    logic [31:0]           out_flush_reg;

    phst_pkg::cell_ctrl_t  ctrl [NS];
    logic                  cell_valid [NS];
    logic [REG_BITS-1:0]   cell_dest [NS];
    logic [2:0]            cell_ready [NS];
    logic [COUNT_BITS-1:0] cell_cnt [NS];
    logic                  cell_match [NS];

    logic                  shift_now;
    logic [2:0]            shift_at;
    logic                  load_now;
    logic                  sel_found;
    logic [2:0]            sel_idx;
    logic signed [4:0]     diff;
    logic [2:0]            bub;
    logic                  out_free;

    assign shift_now = ((state_reg == S_EVAL) && (act_reg == phst_pkg::ACT_CLOCK))
                       || (state_reg == S_RUN);
    assign shift_at  = (state_reg == S_RUN) ? at_reg : stage_reg;
    assign load_now  = (state_reg == S_EVAL) && (act_reg == phst_pkg::ACT_DEST);

    // youngest producer wins: scan from MEM2 down so EXE1 overrides
    always_comb
    begin
        sel_found = 1'b0;
        sel_idx   = phst_pkg::ST_EXE1;
        for (int i = int'(phst_pkg::ST_MEM2); i >= int'(phst_pkg::ST_EXE1); i--)
        begin
            if (cell_match[i])
            begin
                sel_found = 1'b1;
                sel_idx   = 3'(i);
            end
        end
    end

    // (ready - producer) - (needed - ID)
    assign diff = $signed({2'b00, cell_ready[sel_idx]}) - $signed({2'b00, sel_idx})
                  - $signed({2'b00, stage_reg}) + $signed({2'b00, phst_pkg::ST_ID});
    assign bub  = (diff > 5'sd0) ? diff[2:0] : 3'd0;

    genvar g;
    generate
        for (g = 0; g < NS; g++)
        begin : g_cell
            logic                prev_valid;
            logic [REG_BITS-1:0] prev_dest;
            logic [2:0]          prev_ready;

            if (g == 0)
            begin : g_first
                assign prev_valid = 1'b0;
                assign prev_dest  = '0;
                assign prev_ready = '0;
            end
            else
            begin : g_rest
                assign prev_valid = cell_valid[g-1];
                assign prev_dest  = cell_dest[g-1];
                assign prev_ready = cell_ready[g-1];
            end

            assign ctrl[g].shift = shift_now && (3'(g) > shift_at);
            assign ctrl[g].clear = shift_now && (3'(g) == shift_at);
            assign ctrl[g].load  = load_now && (3'(g) == phst_pkg::ST_ID);
            assign ctrl[g].inc   = (state_reg == S_EVAL) && (act_reg == phst_pkg::ACT_SRC)
                                   && sel_found && (3'(g) == sel_idx);

            phst_cell #(
                .REG_BITS   (REG_BITS),
                .COUNT_BITS (COUNT_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl[g]),
                .prev_valid (prev_valid),
                .prev_dest  (prev_dest),
                .prev_ready (prev_ready),
                .load_dest  (key_reg),
                .load_ready (stage_reg),
                .key        (key_reg),
                .valid      (cell_valid[g]),
                .dest       (cell_dest[g]),
                .ready      (cell_ready[g]),
                .count      (cell_cnt[g]),
                .match      (cell_match[g])
            );
        end
    endgenerate

    assign out_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            act_reg        <= phst_pkg::ACT_CLOCK;
            key_reg        <= '0;
            stage_reg      <= '0;
            remain_reg     <= '0;
            at_reg         <= '0;
            found_reg      <= 1'b0;
            hstage_reg     <= '0;
            bub_reg        <= '0;
            cycle_reg      <= COUNT_BITS'(phst_pkg::CYCLE_RESET);
            bubble_reg     <= '0;
            flush_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_bub_reg    <= '0;
            out_found_reg  <= 1'b0;
            out_hstage_reg <= '0;
            out_hcount_reg <= '0;
            out_cycle_reg  <= '0;
            out_bubble_reg <= '0;
            out_flush_reg  <= '0;
        end
        else
        begin
            // in S_DONE the output register is reloaded whenever it is taken
            if (out_valid_reg && result.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        act_reg    <= phst_pkg::action_t'(cmd.action);
                        key_reg    <= REG_BITS'(cmd.reg_num);
                        stage_reg  <= cmd.stage;
                        remain_reg <= cmd.flush_count;
                        found_reg  <= 1'b0;
                        hstage_reg <= '0;
                        bub_reg    <= '0;
                        state_reg  <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    unique case (act_reg)
                        phst_pkg::ACT_CLOCK:
                        begin
                            cycle_reg <= cycle_reg + COUNT_BITS'(1);
                            state_reg <= S_DONE;
                        end
                        phst_pkg::ACT_SRC:
                        begin
                            at_reg <= phst_pkg::ST_EXE1;
                            if (sel_found)
                            begin
                                found_reg  <= 1'b1;
                                hstage_reg <= sel_idx;
                                bub_reg    <= bub;
                                remain_reg <= {1'b0, bub};
                            end
                            state_reg <= (sel_found && bub != 3'd0) ? S_RUN : S_DONE;
                        end
                        phst_pkg::ACT_DEST:
                        begin
                            state_reg <= S_DONE;
                        end
                        phst_pkg::ACT_FLUSH:
                        begin
                            at_reg    <= phst_pkg::ST_IF1;
                            state_reg <= (remain_reg != 4'd0) ? S_RUN : S_DONE;
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_RUN:
                begin
                    // one bubble or flush clock per cycle
                    cycle_reg <= cycle_reg + COUNT_BITS'(1);
                    if (act_reg == phst_pkg::ACT_SRC)
                    begin
                        bubble_reg <= bubble_reg + COUNT_BITS'(1);
                    end
                    else
                    begin
                        flush_reg <= flush_reg + COUNT_BITS'(1);
                    end
                    remain_reg <= remain_reg - 4'd1;
                    if (remain_reg == 4'd1)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_bub_reg    <= bub_reg;
                        out_found_reg  <= found_reg;
                        out_hstage_reg <= hstage_reg;
                        out_hcount_reg <= found_reg ? 32'(cell_cnt[hstage_reg]) : 32'd0;
                        out_cycle_reg  <= 32'(cycle_reg);
                        out_bubble_reg <= 32'(bubble_reg);
                        out_flush_reg  <= 32'(flush_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd.ready               = (state_reg == S_IDLE);
    assign result.valid            = out_valid_reg;
    assign result.bubbles_inserted = out_bub_reg;
    assign result.hazard_found     = out_found_reg;
    assign result.hazard_stage     = out_hstage_reg;
    assign result.hazard_count     = out_hcount_reg;
    assign result.cycle_total      = out_cycle_reg;
    assign result.bubble_total     = out_bubble_reg;
    assign result.flush_total      = out_flush_reg;

endmodule

`default_nettype wire

/* sv/phst_cell.sv */
`default_nettype none

module phst_cell #(
    parameter int REG_BITS   = phst_pkg::REG_BITS_DEF,
    parameter int COUNT_BITS = phst_pkg::COUNT_BITS_DEF
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire phst_pkg::cell_ctrl_t ctrl,
    input  wire                      prev_valid,
    input  wire  [REG_BITS-1:0]      prev_dest,
    input  wire  [2:0]               prev_ready,
    input  wire  [REG_BITS-1:0]      load_dest,
    input  wire  [2:0]               load_ready,
    input  wire  [REG_BITS-1:0]      key,
    output logic                     valid,
    output logic [REG_BITS-1:0]      dest,
    output logic [2:0]               ready,
    output logic [COUNT_BITS-1:0]    count,
    output logic                     match
);

    logic                  valid_reg;
    logic [REG_BITS-1:0]   dest_reg;
    logic [2:0]            ready_reg;
    logic [COUNT_BITS-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dest_reg  <= '0;
            ready_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            priority if (ctrl.clear)
            begin
                valid_reg <= 1'b0;
                dest_reg  <= '0;
                ready_reg <= '0;
            end
            else if (ctrl.shift)
            begin
                valid_reg <= prev_valid;
                dest_reg  <= prev_dest;
                ready_reg <= prev_ready;
            end
            else if (ctrl.load)
            begin
                valid_reg <= 1'b1;
                dest_reg  <= load_dest;
                ready_reg <= load_ready;
            end
            if (ctrl.inc)
            begin
                count_reg <= count_reg + COUNT_BITS'(1);
            end
        end
    end

    assign valid = valid_reg;
    assign dest  = dest_reg;
    assign ready = ready_reg;
    assign count = count_reg;
    assign match = valid_reg && (dest_reg == key);

endmodule

`default_nettype wire

/* sv/phst_checker.sv */
`default_nettype none

module phst_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        cmd_valid,
    input wire        cmd_ready,
    input wire        res_valid,
    input wire        res_ready,
    input wire [2:0]  bubbles_inserted,
    input wire        hazard_found,
    input wire [2:0]  hazard_stage,
    input wire [31:0] hazard_count
);

    // a waiting result stays until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("item accepted while another is in flight");

    a_no_hazard_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !hazard_found |->
            (bubbles_inserted == 3'd0) && (hazard_stage == 3'd0) && (hazard_count == 32'd0))
        else $error("hazard fields set without a producer");

    // producers are searched in EXE1..MEM2 only
    a_hazard_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && hazard_found |->
            (hazard_stage >= phst_pkg::ST_EXE1) && (hazard_stage <= phst_pkg::ST_MEM2))
        else $error("hazard stage outside EXE1..MEM2");

    a_bubble_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (bubbles_inserted != 3'd7))
        else $error("bubble count out of range");

endmodule

bind pipeline_hazard_stall_tracker_top phst_checker u_phst_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd.valid),
    .cmd_ready        (cmd.ready),
    .res_valid        (result.valid),
    .res_ready        (result.ready),
    .bubbles_inserted (result.bubbles_inserted),
    .hazard_found     (result.hazard_found),
    .hazard_stage     (result.hazard_stage),
    .hazard_count     (result.hazard_count)
);

`default_nettype wire

/* dv/tb_pipeline_hazard_stall_tracker_top.sv */
`default_nettype none

module tb_pipeline_hazard_stall_tracker_top;

    import phst_pkg::*;

    typedef struct packed {
        logic [2:0]  bubbles_inserted;
        logic        hazard_found;
        logic [2:0]  hazard_stage;
        logic [31:0] hazard_count;
        logic [31:0] cycle_total;
        logic [31:0] bubble_total;
        logic [31:0] flush_total;
    } res_t;

    typedef struct {
        action_t    act;
        logic [4:0] rn;
        logic [2:0] st;
        logic [3:0] fc;
        bit         typed;
        res_t       want;
    } stim_t;

    localparam int RANDOM_ITEMS = 1950;

    logic clk;
    logic rst_n;

    phst_cmd_if cmd_ch ();
    phst_res_if res_ch ();

    pipeline_hazard_stall_tracker_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (res_ch)
    );

    // shadow copy of the stage records
    logic [4:0]  pipe_dst [NSTAGES];
    bit          pipe_vld [NSTAGES];
    logic [2:0]  pipe_rdy [NSTAGES];
    logic [31:0] pipe_haz [NSTAGES];
    logic [31:0] cycles_seen;
    logic [31:0] bubbles_seen;
    logic [31:0] flushes_seen;

    res_t  pending_results [$];
    stim_t dir_tab [$];
    logic [4:0] reg_pool [4];

    bit burst;
    int items_sent;
    int results_checked;
    int errors;
    int hazards_predicted;
    int stall_items;

    initial
    begin
        clk = 1'b0;
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(8 * 600000);
        $display("** pipeline_hazard_stall_tracker_top: FAILED **");
        $finish;
    end

    function automatic void shift_pipe(logic [2:0] at);
        cycles_seen = cycles_seen + 1;
        for (int i = NSTAGES - 1; i > int'(at); i--)
        begin
            pipe_dst[i] = pipe_dst[i - 1];
            pipe_vld[i] = pipe_vld[i - 1];
            pipe_rdy[i] = pipe_rdy[i - 1];
        end
        pipe_dst[at] = '0;
        pipe_vld[at] = 1'b0;
        pipe_rdy[at] = '0;
    endfunction

    function automatic res_t track_step(action_t a, logic [4:0] rn, logic [2:0] st,
                                        logic [3:0] fc);
        res_t r;
        int have;
        int need;
        int nb;
        r = '0;
        nb = 0;
        case (a)
            ACT_CLOCK: shift_pipe(st);
            ACT_SRC:
            begin
                // youngest producer wins, searched from EXE1 up
                for (int i = int'(ST_EXE1); i <= int'(ST_MEM2); i++)
                begin
                    if (!r.hazard_found && pipe_vld[i] && pipe_dst[i] == rn)
                    begin
                        have = int'(pipe_rdy[i]) - i;
                        need = int'(st) - int'(ST_ID);
                        pipe_haz[i] = pipe_haz[i] + 1;
                        r.hazard_found = 1'b1;
                        r.hazard_stage = 3'(i);
                        r.hazard_count = pipe_haz[i];
                        if (have > need)
                            nb = have - need;
                    end
                end
                r.bubbles_inserted = 3'(nb);
                for (int k = 0; k < nb; k++)
                begin
                    bubbles_seen = bubbles_seen + 1;
                    shift_pipe(ST_EXE1);
                end
            end
            ACT_DEST:
            begin
                pipe_dst[ST_ID] = rn;
                pipe_vld[ST_ID] = 1'b1;
                pipe_rdy[ST_ID] = st;
            end
            default:
            begin
                for (int k = 0; k < int'(fc); k++)
                begin
                    flushes_seen = flushes_seen + 1;
                    shift_pipe(ST_IF1);
                end
            end
        endcase
        r.cycle_total = cycles_seen;
        r.bubble_total = bubbles_seen;
        r.flush_total = flushes_seen;
        return r;
    endfunction

    function automatic res_t mk_res(int b, int f, int hs, int hc, int cy, int bs, int fl);
        res_t r;
        r.bubbles_inserted = 3'(b);
        r.hazard_found = 1'(f);
        r.hazard_stage = 3'(hs);
        r.hazard_count = 32'(hc);
        r.cycle_total = 32'(cy);
        r.bubble_total = 32'(bs);
        r.flush_total = 32'(fl);
        return r;
    endfunction

    function automatic void row(action_t a, logic [4:0] rn, logic [2:0] st, logic [3:0] fc,
                                bit typed, res_t want);
        stim_t s;
        s.act = a;
        s.rn = rn;
        s.st = st;
        s.fc = fc;
        s.typed = typed;
        s.want = want;
        dir_tab.push_back(s);
    endfunction

    function automatic logic [4:0] pick_reg();
        return reg_pool[$urandom_range(0, 3)];
    endfunction

    task automatic issue(action_t a, logic [4:0] rn, logic [2:0] st, logic [3:0] fc,
                         bit typed, res_t want);
        int gap;
        res_t r;
        gap = burst ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.action <= a;
        cmd_ch.reg_num <= rn;
        cmd_ch.stage <= st;
        cmd_ch.flush_count <= fc;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        r = track_step(a, rn, st, fc);
        if (r.hazard_found)
            hazards_predicted++;
        if (r.bubbles_inserted != 0)
            stall_items++;
        pending_results.push_back(typed ? want : r);
        items_sent++;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // result side: random stalls, compare against the oldest expectation
    initial
    begin
        int stall;
        res_t want;
        res_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            stall = burst ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            if (pending_results.size() == 0)
            begin
                $display("%0t: result item with nothing expected", $time);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("bubbles_inserted", 32'(want.bubbles_inserted),
                            32'(res_ch.bubbles_inserted));
                check_field("hazard_found", 32'(want.hazard_found), 32'(res_ch.hazard_found));
                check_field("hazard_stage", 32'(want.hazard_stage), 32'(res_ch.hazard_stage));
                check_field("hazard_count", want.hazard_count, res_ch.hazard_count);
                check_field("cycle_total", want.cycle_total, res_ch.cycle_total);
                check_field("bubble_total", want.bubble_total, res_ch.bubble_total);
                check_field("flush_total", want.flush_total, res_ch.flush_total);
                results_checked++;
            end
        end
    end

    initial
    begin
        int kind;
        int rand_sent;
        for (int i = 0; i < NSTAGES; i++)
        begin
            pipe_dst[i] = '0;
            pipe_vld[i] = 1'b0;
            pipe_rdy[i] = '0;
            pipe_haz[i] = '0;
        end
        cycles_seen = CYCLE_RESET;
        bubbles_seen = '0;
        flushes_seen = '0;
        burst = 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.action <= ACT_CLOCK;
        cmd_ch.reg_num <= '0;
        cmd_ch.stage <= '0;
        cmd_ch.flush_count <= '0;

        // clock at WB from reset, lookup on an empty pipe, deepest stall, flush extremes
        row(ACT_CLOCK, 5'd0, ST_WB, 4'd0, 1, mk_res(0, 0, 0, 0, 8, 0, 0));
        row(ACT_SRC, 5'd0, 3'd0, 4'd0, 1, mk_res(0, 0, 0, 0, 8, 0, 0));
        row(ACT_DEST, 5'd31, ST_WB, 4'd0, 1, mk_res(0, 0, 0, 0, 8, 0, 0));
        row(ACT_CLOCK, 5'd0, ST_ID, 4'd0, 1, mk_res(0, 0, 0, 0, 9, 0, 0));
        row(ACT_SRC, 5'd31, 3'd0, 4'd0, 1, mk_res(6, 1, 3, 1, 15, 6, 0));
        row(ACT_FLUSH, 5'd0, 3'd0, 4'd15, 1, mk_res(0, 0, 0, 0, 30, 6, 15));
        row(ACT_FLUSH, 5'd31, 3'd7, 4'd0, 1, mk_res(0, 0, 0, 0, 30, 6, 15));
        // two producers of one register: the younger one must win
        row(ACT_DEST, 5'd5, 3'd4, 4'd0, 0, '0);
        row(ACT_CLOCK, 5'd0, 3'd1, 4'd0, 0, '0);
        row(ACT_DEST, 5'd5, 3'd6, 4'd0, 0, '0);
        row(ACT_CLOCK, 5'd0, ST_ID, 4'd0, 0, '0);
        row(ACT_SRC, 5'd5, ST_EXE1, 4'd0, 0, '0);
        row(ACT_SRC, 5'd5, ST_WB, 4'd0, 0, '0);
        // producer ready before its own stage, register zero
        row(ACT_DEST, 5'd0, 3'd0, 4'd0, 0, '0);
        row(ACT_CLOCK, 5'd0, ST_IF1, 4'd0, 0, '0);
        row(ACT_SRC, 5'd0, ST_ID, 4'd0, 0, '0);
        row(ACT_CLOCK, 5'd0, ST_WB, 4'd0, 0, '0);
        row(ACT_CLOCK, 5'd0, ST_MEM2, 4'd0, 0, '0);
        row(ACT_FLUSH, 5'd0, 3'd0, 4'd3, 0, '0);
        row(ACT_DEST, 5'd31, 3'd5, 4'd0, 0, '0);
        row(ACT_CLOCK, 5'd0, ST_ID, 4'd0, 0, '0);
        row(ACT_SRC, 5'd30, 3'd5, 4'd0, 0, '0);
        row(ACT_SRC, 5'd31, ST_ID, 4'd0, 0, '0);
        row(ACT_CLOCK, 5'd0, ST_EXE1, 4'd0, 0, '0);
        row(ACT_CLOCK, 5'd0, 3'd4, 4'd0, 0, '0);
        row(ACT_CLOCK, 5'd0, 3'd5, 4'd0, 0, '0);

        wait (rst_n);
        @(posedge clk);
        foreach (dir_tab[i])
            issue(dir_tab[i].act, dir_tab[i].rn, dir_tab[i].st, dir_tab[i].fc,
                  dir_tab[i].typed, dir_tab[i].want);

        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS)
        begin
            if (rand_sent % 100 < 12)
            begin
                foreach (reg_pool[k])
                    reg_pool[k] = 5'($urandom_range(0, 31));
                if ($urandom_range(0, 3) == 0)
                    reg_pool[0] = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'd31;
            end
            if (rand_sent % 64 < 8)
                burst = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                // producers moved into EXE1 and beyond, then consumers
                repeat ($urandom_range(1, 3))
                begin
                    issue(ACT_DEST, pick_reg(), 3'($urandom_range(0, 7)),
                          4'($urandom_range(0, 15)), 0, '0);
                    issue(ACT_CLOCK, 5'($urandom_range(0, 31)), 3'($urandom_range(0, 2)),
                          4'($urandom_range(0, 15)), 0, '0);
                    rand_sent += 2;
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    issue(ACT_CLOCK, 5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                          4'($urandom_range(0, 15)), 0, '0);
                    rand_sent++;
                end
                repeat ($urandom_range(1, 2))
                begin
                    issue(ACT_SRC, pick_reg(), 3'($urandom_range(0, 7)),
                          4'($urandom_range(0, 15)), 0, '0);
                    rand_sent++;
                end
            end
            else if (kind == 7)
            begin
                issue(ACT_FLUSH, 5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                      ($urandom_range(0, 7) == 0) ? 4'd15 : 4'($urandom_range(0, 3)), 0, '0);
                rand_sent++;
            end
            else
            begin
                issue(action_t'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                      3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), 0, '0);
                rand_sent++;
            end
        end
        cmd_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("sent %0d items, checked %0d results", items_sent, results_checked);
        $display("raw hazards predicted: %0d, items with stall bubbles: %0d",
                 hazards_predicted, stall_items);
        if (errors == 0)
            $display("** pipeline_hazard_stall_tracker_top: PASSED **");
        else
            $display("** pipeline_hazard_stall_tracker_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
